// ----- hdl/hwlp_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP weighted list parser package
// Shared types, register indexes, reset values and defaults for the parser.
// ----------------------------------------------------------------------------
package hwlp_pkg;

  localparam int TokenCapacityDef = 32;

  localparam logic [7:0]  MaxValuesRst    = 8'd16;
  localparam logic        WeightedModeRst = 1'b1;
  localparam logic [15:0] WeightBaseRst   = 16'd0;

  typedef enum logic [1:0] {
    CFG_MAX_VALUES    = 2'd0,
    CFG_WEIGHTED_MODE = 2'd1,
    CFG_WEIGHT_BASE   = 2'd2
  } cfg_index_e;

  typedef enum logic [6:0] {
    PH_SKIP   = 7'b0000001,
    PH_TOKEN  = 7'b0000010,
    PH_MATCH  = 7'b0000100,
    PH_DIGITS = 7'b0001000,
    PH_REST   = 7'b0010000,
    PH_DRAIN  = 7'b0100000,
    PH_LF     = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0]  max_values;
    logic        weighted_mode;
    logic [15:0] weight_base;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  token_count;
    logic [4:0]  char_count;
    logic [2:0]  match_pos;
    logic [1:0]  digit_count;
    logic [9:0]  weight_acc;
    logic        weight_seen;
    logic [15:0] byte_count;
  } line_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  token_index;
    logic [4:0]  char_pos;
    logic [7:0]  token_char;
    logic        weight_given;
    logic [15:0] weight;
    logic [15:0] line_length;
  } result_t;

  localparam line_state_t LineStateRst = '{
    phase:       PH_SKIP,
    token_count: 8'd0,
    char_count:  5'd0,
    match_pos:   3'd0,
    digit_count: 2'd0,
    weight_acc:  10'd0,
    weight_seen: 1'b0,
    byte_count:  16'd0
  };

endpackage

// ----- hdl/hwlp_step.sv -----
// ----------------------------------------------------------------------------
// HTTP weighted list parser step logic
// Computes the next line state and the optional result for one input byte.
// ----------------------------------------------------------------------------
module hwlp_step #(
  parameter int TokenCapacity = hwlp_pkg::TokenCapacityDef
) (
  input  hwlp_pkg::cfg_t        cfg_i,
  input  hwlp_pkg::line_state_t state_i,
  input  logic [7:0]            byte_i,
  input  logic                  eob_i,
  output hwlp_pkg::line_state_t state_o,
  output hwlp_pkg::result_t     res_o,
  output logic                  res_valid_o
);

  localparam logic [4:0] CharLimit =
    ((TokenCapacity - 1) > 31) ? 5'd31 : 5'(TokenCapacity - 1);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChQ     = 8'h71;

  function automatic logic [7:0] pattern_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd1:    c = ChQ;
      3'd2:    c = ChEq;
      3'd3:    c = ChZero;
      3'd4:    c = ChDot;
      default: c = ChNul;
    endcase
    return c;
  endfunction

  logic        is_comma, is_cr, is_nul, is_digit;
  logic [7:0]  cnt_inc;
  logic        full_after, full_at_end;
  logic [13:0] acc_w, acc_dig_w, acc_fin_w;
  logic [9:0]  end_acc;
  logic        end_seen;
  logic [16:0] weight_sum;
  logic [15:0] weight_sat;
  logic        match_hit;
  logic        go_rest, do_end, reject, accept;

  assign is_comma = (byte_i == ChComma);
  assign is_cr    = (byte_i == ChCr);
  assign is_nul   = (byte_i == ChNul);
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);

  assign cnt_inc     = (state_i.token_count == 8'hFF) ? 8'hFF : state_i.token_count + 8'd1;
  assign full_after  = ({1'b0, state_i.token_count} + 9'd1) >= {1'b0, cfg_i.max_values};
  assign full_at_end = cnt_inc >= cfg_i.max_values;

  assign acc_w     = {4'd0, state_i.weight_acc};
  assign acc_dig_w = acc_w * 14'd10 + {10'd0, byte_i[3:0]};

  always_comb begin
    case (state_i.digit_count)
      2'd0:    acc_fin_w = acc_w * 14'd1000;
      2'd1:    acc_fin_w = acc_w * 14'd100;
      2'd2:    acc_fin_w = acc_w * 14'd10;
      default: acc_fin_w = acc_w;
    endcase
  end

  assign end_acc    = (state_i.phase == hwlp_pkg::PH_DIGITS) ? acc_fin_w[9:0]
                                                             : state_i.weight_acc;
  assign end_seen   = (state_i.phase == hwlp_pkg::PH_DIGITS) || state_i.weight_seen;
  assign weight_sum = {1'b0, cfg_i.weight_base} + {7'd0, end_acc};
  assign weight_sat = weight_sum[16] ? 16'hFFFF : weight_sum[15:0];

  assign match_hit = (state_i.match_pos >= 3'd1) && (state_i.match_pos <= 3'd4) &&
                     (byte_i == pattern_char(state_i.match_pos));

  always_comb begin
    state_o     = state_i;
    res_o       = '0;
    res_valid_o = 1'b0;
    go_rest     = 1'b0;
    do_end      = 1'b0;
    reject      = 1'b0;
    accept      = 1'b0;

    state_o.byte_count = (state_i.byte_count == 16'hFFFF) ? 16'hFFFF
                                                          : state_i.byte_count + 16'd1;

    case (state_i.phase)
      hwlp_pkg::PH_SKIP: begin
        if (byte_i == ChSp || is_comma) begin
          state_o.phase = hwlp_pkg::PH_SKIP;
        end else if (is_cr) begin
          state_o.phase = hwlp_pkg::PH_LF;
        end else if (is_nul || (cfg_i.weighted_mode && byte_i == ChSemi)) begin
          reject = 1'b1;
        end else begin
          res_o.kind        = hwlp_pkg::KIND_BYTE;
          res_o.token_index = state_i.token_count;
          res_o.token_char  = byte_i;
          res_valid_o       = 1'b1;
          state_o.char_count = 5'd1;
          state_o.phase      = hwlp_pkg::PH_TOKEN;
        end
      end
      hwlp_pkg::PH_TOKEN: begin
        if (is_comma || is_cr || is_nul) begin
          go_rest = 1'b1;
        end else if (state_i.char_count < CharLimit &&
                     !(cfg_i.weighted_mode && byte_i == ChSemi)) begin
          res_o.kind         = hwlp_pkg::KIND_BYTE;
          res_o.token_index  = state_i.token_count;
          res_o.char_pos     = state_i.char_count;
          res_o.token_char   = byte_i;
          res_valid_o        = 1'b1;
          state_o.char_count = state_i.char_count + 5'd1;
        end else if (cfg_i.weighted_mode) begin
          if (byte_i == ChSemi) begin
            state_o.phase     = hwlp_pkg::PH_MATCH;
            state_o.match_pos = 3'd1;
          end else begin
            state_o.phase = hwlp_pkg::PH_REST;
          end
        end else if (byte_i == ChSp) begin
          do_end        = 1'b1;
          state_o.phase = full_at_end ? hwlp_pkg::PH_DRAIN : hwlp_pkg::PH_SKIP;
        end else if (full_after) begin
          do_end        = 1'b1;
          state_o.phase = hwlp_pkg::PH_DRAIN;
        end else begin
          res_o.kind          = hwlp_pkg::KIND_BYTE;
          res_o.token_index   = cnt_inc;
          res_o.token_char    = byte_i;
          res_valid_o         = 1'b1;
          state_o.token_count = cnt_inc;
          state_o.char_count  = 5'd1;
        end
      end
      hwlp_pkg::PH_MATCH: begin
        if (match_hit) begin
          state_o.match_pos = state_i.match_pos + 3'd1;
          if (state_i.match_pos == 3'd4) begin
            state_o.phase       = hwlp_pkg::PH_DIGITS;
            state_o.digit_count = 2'd0;
            state_o.weight_acc  = 10'd0;
          end
        end else begin
          state_o.match_pos = 3'd0;
          go_rest           = 1'b1;
        end
      end
      hwlp_pkg::PH_DIGITS: begin
        if (is_digit && state_i.digit_count < 2'd3) begin
          state_o.weight_acc  = acc_dig_w[9:0];
          state_o.digit_count = state_i.digit_count + 2'd1;
          if (state_i.digit_count == 2'd2) begin
            state_o.weight_seen = 1'b1;
            state_o.phase       = hwlp_pkg::PH_REST;
          end
        end else begin
          state_o.weight_acc  = acc_fin_w[9:0];
          state_o.weight_seen = 1'b1;
          go_rest             = 1'b1;
        end
      end
      hwlp_pkg::PH_REST: begin
        go_rest = 1'b1;
      end
      hwlp_pkg::PH_DRAIN: begin
        if (is_cr) begin
          state_o.phase = hwlp_pkg::PH_LF;
        end
      end
      hwlp_pkg::PH_LF: begin
        if (byte_i == ChLf) begin
          accept = 1'b1;
        end else begin
          reject = 1'b1;
        end
      end
      default: begin
        reject = 1'b1;
      end
    endcase

    if (go_rest) begin
      if (is_comma) begin
        do_end        = 1'b1;
        state_o.phase = full_at_end ? hwlp_pkg::PH_DRAIN : hwlp_pkg::PH_SKIP;
      end else if (is_cr) begin
        do_end        = 1'b1;
        state_o.phase = hwlp_pkg::PH_LF;
      end else if (is_nul) begin
        if (full_after) begin
          do_end        = 1'b1;
          state_o.phase = hwlp_pkg::PH_DRAIN;
        end else begin
          reject = 1'b1;
        end
      end else begin
        state_o.phase = hwlp_pkg::PH_REST;
      end
    end

    if (do_end) begin
      res_o.kind           = hwlp_pkg::KIND_END;
      res_o.token_index    = state_i.token_count;
      res_o.char_pos       = state_i.char_count;
      res_o.token_char     = 8'd0;
      res_o.weight_given   = end_seen;
      res_o.weight         = end_seen ? weight_sat : 16'd0;
      res_valid_o          = 1'b1;
      state_o.token_count  = cnt_inc;
      state_o.char_count   = 5'd0;
      state_o.match_pos    = 3'd0;
      state_o.digit_count  = 2'd0;
      state_o.weight_acc   = 10'd0;
      state_o.weight_seen  = 1'b0;
    end

    if (accept) begin
      res_o             = '0;
      res_o.kind        = hwlp_pkg::KIND_ACCEPT;
      res_o.token_index = state_i.token_count;
      res_o.line_length = state_o.byte_count;
      res_valid_o       = 1'b1;
      state_o           = hwlp_pkg::LineStateRst;
    end else if (reject || eob_i) begin
      res_o       = '0;
      res_o.kind  = hwlp_pkg::KIND_REJECT;
      res_valid_o = 1'b1;
      state_o     = hwlp_pkg::LineStateRst;
    end
  end

endmodule

// ----- hdl/http_weighted_list_parser.sv -----
// ----------------------------------------------------------------------------
// HTTP weighted list parser
// Splits an HTTP list header value into tokens with optional q weights.
// ----------------------------------------------------------------------------
// The parser takes one header byte per transaction and sustains one byte per
// clock cycle while the result side keeps taking results. A byte passes through
// an input register, the combinational step logic updates the line state, and at
// most one result lands in the output register, which presents it. The
// output register decouples the two sides: a new byte is taken while a result
// waits, and the pipeline stalls only when both registers are full. Each byte
// gives a token byte, a token end, a line accept, a line reject or nothing.
// Configuration writes are taken in any cycle and should be issued only while
// the parser is idle between lines.
module http_weighted_list_parser #(
  parameter int TokenCapacity = hwlp_pkg::TokenCapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  token_index_o,
  output logic [4:0]  char_pos_o,
  output logic [7:0]  token_char_o,
  output logic        weight_given_o,
  output logic [15:0] weight_o,
  output logic [15:0] line_length_o
);

  localparam logic [4:0] CharLimit =
    ((TokenCapacity - 1) > 31) ? 5'd31 : 5'(TokenCapacity - 1);

  hwlp_pkg::cfg_t        cfg_q;
  hwlp_pkg::line_state_t state_q, state_d;
  hwlp_pkg::result_t     res_q, res_d;
  logic                  res_valid_d;
  logic                  in_valid_q, out_valid_q;
  logic [7:0]            in_byte_q;
  logic                  in_eob_q;
  logic                  advance, step_fire;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || out_ready_i;
  assign step_fire   = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_values    <= hwlp_pkg::MaxValuesRst;
      cfg_q.weighted_mode <= hwlp_pkg::WeightedModeRst;
      cfg_q.weight_base   <= hwlp_pkg::WeightBaseRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hwlp_pkg::CFG_MAX_VALUES:    cfg_q.max_values    <= cfg_data_i[7:0];
        hwlp_pkg::CFG_WEIGHTED_MODE: cfg_q.weighted_mode <= cfg_data_i[0];
        hwlp_pkg::CFG_WEIGHT_BASE:   cfg_q.weight_base   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_eob_q  <= end_of_buffer_i;
    end
  end

  hwlp_step #(
    .TokenCapacity(TokenCapacity)
  ) u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .byte_i     (in_byte_q),
    .eob_i      (in_eob_q),
    .state_o    (state_d),
    .res_o      (res_d),
    .res_valid_o(res_valid_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hwlp_pkg::LineStateRst;
      out_valid_q <= 1'b0;
    end else begin
      if (step_fire) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && res_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = res_q.kind;
  assign token_index_o  = res_q.token_index;
  assign char_pos_o     = res_q.char_pos;
  assign token_char_o   = res_q.token_char;
  assign weight_given_o = res_q.weight_given;
  assign weight_o       = res_q.weight;
  assign line_length_o  = res_q.line_length;

  // A line accept or reject always returns the line state to its start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && res_valid_d &&
    (res_d.kind == hwlp_pkg::KIND_ACCEPT || res_d.kind == hwlp_pkg::KIND_REJECT)
    |=> state_q.byte_count == 16'd0 && state_q.phase == hwlp_pkg::PH_SKIP)
    else $error("line state not cleared after line result");

  // The input side stalls only when both pipeline registers hold data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

  // Token bytes never land beyond the token capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == hwlp_pkg::KIND_BYTE |-> char_pos_o < CharLimit)
    else $error("token byte position beyond capacity");

  // Only a token end ever carries a weight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != hwlp_pkg::KIND_END |-> !weight_given_o && weight_o == 16'd0)
    else $error("weight reported outside a token end");

endmodule

// ----- tb/hwlp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP weighted list parser checker
// Watches the configuration, byte and result channels of the parser. Every
// accepted byte is run through a cycle-free copy of the parsing rules, and the
// result it gives is queued. Every accepted result is compared field by field
// with the oldest queued one. Mismatches and results nobody expected are
// counted and reported to the testbench top.
// ----------------------------------------------------------------------------
module hwlp_checker #(
  parameter int TokenCapacity = hwlp_pkg::TokenCapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_buffer_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  token_index_i,
  input  logic [4:0]  char_pos_i,
  input  logic [7:0]  token_char_i,
  input  logic        weight_given_i,
  input  logic [15:0] weight_i,
  input  logic [15:0] line_length_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned CharLimit = (TokenCapacity - 1 > 31) ? 31 : TokenCapacity - 1;
  localparam logic [31:0] QPattern = "q=0.";
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  logic [7:0]  max_values;
  logic        weighted_mode;
  logic [15:0] weight_base;

  hwlp_pkg::phase_e  ph;
  int unsigned       tok_cnt;
  int unsigned       chr_cnt;
  int unsigned       mpos;
  int unsigned       dig_cnt;
  int unsigned       wacc;
  bit                wseen;
  int unsigned       byte_cnt;

  hwlp_pkg::result_t predicted;
  hwlp_pkg::result_t pending_results[$];
  int                errors;

  function automatic void clear_line();
    ph       = hwlp_pkg::PH_SKIP;
    tok_cnt  = 0;
    chr_cnt  = 0;
    mpos     = 0;
    dig_cnt  = 0;
    wacc     = 0;
    wseen    = 0;
    byte_cnt = 0;
  endfunction

  function automatic hwlp_pkg::result_t pack_result(input hwlp_pkg::kind_e k,
                                                    input int unsigned idx,
                                                    input int unsigned pos,
                                                    input int unsigned ch,
                                                    input int unsigned wg,
                                                    input int unsigned w,
                                                    input int unsigned len);
    hwlp_pkg::result_t r;
    r.kind         = k;
    r.token_index  = idx[7:0];
    r.char_pos     = pos[4:0];
    r.token_char   = ch[7:0];
    r.weight_given = wg[0];
    r.weight       = w[15:0];
    r.line_length  = len[15:0];
    return r;
  endfunction

  function automatic bit count_full();
    return tok_cnt + 1 >= max_values;
  endfunction

  function automatic void end_token();
    int unsigned w;
    w = 0;
    if (wseen) begin
      w = (weight_base + wacc > 65535) ? 65535 : weight_base + wacc;
    end
    predicted = pack_result(hwlp_pkg::KIND_END, tok_cnt, chr_cnt, 0, 32'(wseen), w, 0);
    if (tok_cnt < 255) tok_cnt++;
    chr_cnt = 0;
    mpos    = 0;
    dig_cnt = 0;
    wacc    = 0;
    wseen   = 0;
  endfunction

  function automatic void after_end();
    ph = (tok_cnt >= max_values) ? hwlp_pkg::PH_DRAIN : hwlp_pkg::PH_SKIP;
  endfunction

  function automatic int nul_end();
    if (!count_full()) return -1;
    end_token();
    ph = hwlp_pkg::PH_DRAIN;
    return 1;
  endfunction

  function automatic int rest_byte(input logic [7:0] b);
    if (b == ChComma) begin
      end_token();
      after_end();
      return 1;
    end
    if (b == ChCr) begin
      end_token();
      ph = hwlp_pkg::PH_LF;
      return 1;
    end
    if (b == ChNul) return nul_end();
    ph = hwlp_pkg::PH_REST;
    return 0;
  endfunction

  function automatic void finish_weight();
    for (int unsigned k = dig_cnt; k < 3; k++) wacc = wacc * 10;
    wacc  = wacc & 10'h3FF;
    wseen = 1;
  endfunction

  function automatic void emit_char(input logic [7:0] b);
    predicted = pack_result(hwlp_pkg::KIND_BYTE, tok_cnt, chr_cnt, 32'(b), 0, 0, 0);
    chr_cnt++;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eob, output bit got);
    int r;
    bit accepted;
    r = 0;
    accepted = 0;
    if (byte_cnt < 65535) byte_cnt++;
    case (ph)
      hwlp_pkg::PH_SKIP: begin
        if (b == ChSpace || b == ChComma) begin
          r = 0;
        end else if (b == ChCr) begin
          ph = hwlp_pkg::PH_LF;
        end else if (b == ChNul || (weighted_mode && b == ChSemi)) begin
          r = -1;
        end else begin
          chr_cnt = 0;
          emit_char(b);
          ph = hwlp_pkg::PH_TOKEN;
          r = 1;
        end
      end
      hwlp_pkg::PH_TOKEN: begin
        if (b == ChComma || b == ChCr || b == ChNul) begin
          r = rest_byte(b);
        end else if (weighted_mode) begin
          if (b == ChSemi) begin
            ph = hwlp_pkg::PH_MATCH;
            mpos = 1;
          end else if (chr_cnt < CharLimit) begin
            emit_char(b);
            r = 1;
          end else begin
            ph = hwlp_pkg::PH_REST;
          end
        end else if (chr_cnt < CharLimit) begin
          emit_char(b);
          r = 1;
        end else if (b == ChSpace) begin
          end_token();
          after_end();
          r = 1;
        end else if (count_full()) begin
          end_token();
          ph = hwlp_pkg::PH_DRAIN;
          r = 1;
        end else begin
          if (tok_cnt < 255) tok_cnt++;
          chr_cnt = 0;
          emit_char(b);
          r = 1;
        end
      end
      hwlp_pkg::PH_MATCH: begin
        if (mpos >= 1 && mpos <= 4 && b == QPattern[8 * (4 - mpos) +: 8]) begin
          mpos++;
          if (mpos == 5) begin
            ph = hwlp_pkg::PH_DIGITS;
            dig_cnt = 0;
            wacc = 0;
          end
        end else begin
          mpos = 0;
          r = rest_byte(b);
        end
      end
      hwlp_pkg::PH_DIGITS: begin
        if (b >= ChZero && b <= ChNine && dig_cnt < 3) begin
          wacc = (wacc * 10 + (b - ChZero)) & 10'h3FF;
          dig_cnt++;
          if (dig_cnt == 3) begin
            finish_weight();
            ph = hwlp_pkg::PH_REST;
          end
        end else begin
          finish_weight();
          r = rest_byte(b);
        end
      end
      hwlp_pkg::PH_REST: r = rest_byte(b);
      hwlp_pkg::PH_DRAIN: begin
        if (b == ChCr) ph = hwlp_pkg::PH_LF;
      end
      hwlp_pkg::PH_LF: begin
        if (b == ChLf) accepted = 1;
        else r = -1;
      end
      default: r = -1;
    endcase
    if (accepted) begin
      predicted = pack_result(hwlp_pkg::KIND_ACCEPT, tok_cnt, 0, 0, 0, 0, byte_cnt);
      clear_line();
      got = 1;
    end else if (r < 0 || eob) begin
      predicted = pack_result(hwlp_pkg::KIND_REJECT, 0, 0, 0, 0, 0, 0);
      clear_line();
      got = 1;
    end else begin
      got = (r > 0);
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hwlp_pkg::result_t exp_r;
    bit                got;
    if (!rst_ni) begin
      max_values    = hwlp_pkg::MaxValuesRst;
      weighted_mode = hwlp_pkg::WeightedModeRst;
      weight_base   = hwlp_pkg::WeightBaseRst;
      clear_line();
      pending_results.delete();
      errors        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual kind %0d", $time, kind_i);
        end else begin
          exp_r = pending_results.pop_front();
          check_field("kind", 16'(exp_r.kind), 16'(kind_i));
          check_field("token_index", 16'(exp_r.token_index), 16'(token_index_i));
          check_field("char_pos", 16'(exp_r.char_pos), 16'(char_pos_i));
          check_field("token_char", 16'(exp_r.token_char), 16'(token_char_i));
          check_field("weight_given", 16'(exp_r.weight_given), 16'(weight_given_i));
          check_field("weight", exp_r.weight, weight_i);
          check_field("line_length", exp_r.line_length, line_length_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (hwlp_pkg::cfg_index_e'(cfg_index_i))
          hwlp_pkg::CFG_MAX_VALUES:    max_values    = cfg_data_i[7:0];
          hwlp_pkg::CFG_WEIGHTED_MODE: weighted_mode = cfg_data_i[0];
          hwlp_pkg::CFG_WEIGHT_BASE:   weight_base   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(in_byte_i, end_of_buffer_i, got);
        if (got) pending_results.push_back(predicted);
      end
      fail_count_o <= errors;
      pending_o    <= pending_results.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP weighted list parser testbench
// Resets the parser, feeds a few directed header lines and then random lines,
// mostly well formed with random tokens, weights and endings, the rest noise,
// under several register settings. Bytes are sent in bursts with random gaps
// while the result side stalls on its own pattern. A checker beside the
// parser predicts and compares every result and reports its failure count.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TotalBytes = 1500;
  localparam int PhaseBytes = 150;
  localparam int CycleLimit = 500000;
  localparam logic [7:0] Specials [10] = '{",", ";", "\r", "\n", " ", 8'h00,
                                           "q", "=", "0", "."};

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic [1:0]  cfg_index_i     = 2'd0;
  logic [15:0] cfg_data_i      = 16'd0;
  logic        in_valid_i      = 1'b0;
  logic [7:0]  in_byte_i       = 8'd0;
  logic        end_of_buffer_i = 1'b0;
  logic        out_ready_i     = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  token_index_o;
  logic [4:0]  char_pos_o;
  logic [7:0]  token_char_o;
  logic        weight_given_o;
  logic [15:0] weight_o;
  logic [15:0] line_length_o;

  int          fail_count;
  int          pending;
  int          cycles;
  int          sent;
  int          burst_left;
  bit          gappy;
  int          rx_left;
  int          rx_mode;
  logic [7:0]  line_bytes[$];
  logic        line_eob[$];

  always #1 clk_i = ~clk_i;

  http_weighted_list_parser i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .end_of_buffer_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .token_index_o,
    .char_pos_o,
    .token_char_o,
    .weight_given_o,
    .weight_o,
    .line_length_o
  );

  hwlp_checker #(
    .TokenCapacity(hwlp_pkg::TokenCapacityDef)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .in_byte_i,
    .end_of_buffer_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .kind_i          (kind_o),
    .token_index_i   (token_index_o),
    .char_pos_i      (char_pos_o),
    .token_char_i    (token_char_o),
    .weight_given_i  (weight_given_o),
    .weight_i        (weight_o),
    .line_length_i   (line_length_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= rx_left[1];
    endcase
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    if (burst_left <= 0) begin
      gap = (gappy && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_buffer_i <= eob;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eob);
    line_bytes.push_back(b);
    line_eob.push_back(eob);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic flush_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i], line_eob[i]);
    line_bytes.delete();
    line_eob.delete();
  endtask

  // The byte with end of buffer set closes any line left open, so every
  // register write lands between lines.
  task automatic new_settings(input logic [7:0] max_v, input logic wmode,
                              input logic [15:0] base);
    hwlp_pkg::cfg_index_e idx [3];
    logic [15:0] data [3];
    idx  = '{hwlp_pkg::CFG_MAX_VALUES, hwlp_pkg::CFG_WEIGHTED_MODE,
             hwlp_pkg::CFG_WEIGHT_BASE};
    data = '{{8'd0, max_v}, {15'd0, wmode}, base};
    send_byte(" ", 1'b1);
    in_valid_i <= 1'b0;
    burst_left = 0;
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    gappy = ($urandom_range(0, 2) != 0);
  endtask

  task automatic add_token();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
    repeat (len) begin
      case ($urandom_range(0, 15))
        10, 11:  push_byte(8'($urandom_range(128, 255)), 1'b0);
        12:      push_byte(8'($urandom_range(33, 126)), 1'b0);
        13:      push_byte(" ", 1'b0);
        14:      push_byte(8'($urandom_range(48, 57)), 1'b0);
        15:      push_byte(8'($urandom_range(0, 255)), 1'b0);
        default: push_byte(8'($urandom_range(97, 122)), 1'b0);
      endcase
    end
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        push_str(";q=0.");
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(48, 57)), 1'b0);
      end
      4: begin
        push_str(";q=0.");
        push_byte(8'($urandom_range(48, 57)), 1'b0);
        push_byte(8'($urandom_range(33, 126)), 1'b0);
      end
      5: begin
        push_str(";q=");
        push_byte(8'($urandom_range(33, 126)), 1'b0);
      end
      6: begin
        push_str(";");
        push_byte(8'($urandom_range(33, 126)), 1'b0);
      end
      default: ;
    endcase
  endtask

  task automatic random_line();
    int ntok;
    if ($urandom_range(0, 9) < 8) begin
      repeat ($urandom_range(0, 2)) push_byte(($urandom_range(0, 1) == 1) ? "," : " ", 1'b0);
      ntok = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      for (int t = 0; t < ntok; t++) begin
        add_token();
        if (t < ntok - 1) begin
          case ($urandom_range(0, 3))
            0:       push_str(",");
            1:       push_str(", ");
            2:       push_str(" ,");
            default: push_str(",,");
          endcase
        end
      end
      case ($urandom_range(0, 19))
        0: begin
          push_str("\r");
          push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        1: begin
          push_byte(8'h00, 1'b0);
          push_str("\r\n");
        end
        2:       push_str(",;\r\n");
        default: push_str("\r\n");
      endcase
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
        else push_byte(Specials[$urandom_range(0, 9)], 1'b0);
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      line_eob[$urandom_range(0, line_bytes.size() - 1)] = 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      line_eob[line_bytes.size() - 1] = 1'b1;
    end
    flush_line();
  endtask

  initial begin
    int phase_end;
    sent       = 0;
    burst_left = 0;
    gappy      = 1'b1;
    rx_left    = 0;
    rx_mode    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_str("a;q=0.5,b;q=0.123\r\n");
    push_str("c;x\r\n");
    push_str(";");
    push_byte(8'h00, 1'b0);
    push_str("d");
    push_byte(8'h00, 1'b0);
    push_str("x\ry");
    push_byte(8'hFF, 1'b1);
    flush_line();

    for (int p = 0; p < 4 || sent < TotalBytes; p++) begin
      case (p)
        0:       new_settings(8'd255, 1'b0, 16'd0);
        1:       new_settings(8'd1, 1'b1, 16'd64536);
        2:       new_settings(8'd2, 1'b0, 16'd999);
        3:       new_settings(8'd16, 1'b1, 16'($urandom_range(0, 64536)));
        default: new_settings(8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                             : $urandom_range(1, 4)),
                              1'($urandom_range(0, 1)),
                              ($urandom_range(0, 2) == 0) ? 16'd64536
                                                          : 16'($urandom_range(0, 64536)));
      endcase
      if (p == 0) begin
        repeat (256) push_str("x,");
        push_str("\r\n");
        flush_line();
      end
      phase_end = sent + PhaseBytes;
      while (sent < phase_end) random_line();
    end

    in_valid_i <= 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
